// File: sv/gate_motor_controller_fsm_assert.svh
// Assertion macros used by the gate motor controller RTL.
`ifndef GATE_MOTOR_CONTROLLER_FSM_ASSERT_SVH
`define GATE_MOTOR_CONTROLLER_FSM_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define GMC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define GMC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define GMC_ASSERT_NOW(label, ante, cons, msg)
`define GMC_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// File: sv/gmc_pkg.sv
// Types, codes and helpers for the gate motor controller.
package gmc_pkg;

  // External state codes as reported on the result beat
  localparam logic [2:0] GS_STOP_OPEN   = 3'd0;
  localparam logic [2:0] GS_STOP_CLOSE  = 3'd1;
  localparam logic [2:0] GS_OPEN        = 3'd2;
  localparam logic [2:0] GS_CLOSE       = 3'd3;
  localparam logic [2:0] GS_REVERSE     = 3'd4;
  localparam logic [2:0] GS_OPEN_LIMIT  = 3'd5;
  localparam logic [2:0] GS_CLOSE_LIMIT = 3'd6;

  typedef enum logic [6:0] {
    ST_STOP_OPEN   = 7'b0000001,
    ST_STOP_CLOSE  = 7'b0000010,
    ST_OPEN        = 7'b0000100,
    ST_CLOSE       = 7'b0001000,
    ST_REVERSE     = 7'b0010000,
    ST_OPEN_LIMIT  = 7'b0100000,
    ST_CLOSE_LIMIT = 7'b1000000
  } gate_st_t;

  typedef enum logic [1:0] {
    DRIVE_STOP  = 2'd0,
    DRIVE_OPEN  = 2'd1,
    DRIVE_CLOSE = 2'd2
  } drive_t;

  // One input beat, decoded into named fields
  typedef struct packed {
    logic stop;
    logic open_limit;
    logic close_limit;
    logic reverse_delay_done;
    logic open_request;
    logic aux_open_request;
    logic single_button;
    logic close_request;
    logic reverse_request;
    logic reverse_pause_done;
  } gmc_in_t;

  function automatic logic [2:0] state_code(gate_st_t st);
    logic [2:0] code;
    case (st)
      ST_STOP_OPEN:   code = GS_STOP_OPEN;
      ST_STOP_CLOSE:  code = GS_STOP_CLOSE;
      ST_OPEN:        code = GS_OPEN;
      ST_CLOSE:       code = GS_CLOSE;
      ST_REVERSE:     code = GS_REVERSE;
      ST_OPEN_LIMIT:  code = GS_OPEN_LIMIT;
      ST_CLOSE_LIMIT: code = GS_CLOSE_LIMIT;
      default:        code = GS_STOP_OPEN;
    endcase
    return code;
  endfunction

endpackage

// File: sv/gate_motor_controller_fsm.sv
// Gate motor controller: seven-state drive sequencer with registered result.
//
// Usage:
//   Input channel (in_*): one beat per tick carries the qualified switch
//   levels and the two timer-done flags. Result channel (out_*): one beat
//   per input beat carries motor drive, the two timer-clear strobes and the
//   gate state after the tick.
//   Path: an accepted beat goes through one input register, then one result
//   register. Throughput: one beat per clock while out_tready is high. The
//   rate is set by the next-state logic around the single state register,
//   which updates when a beat moves from the input register into the result
//   register.
//   Drive and clear strobes come from the state held before the tick;
//   gate_state reports the state after it.
//   Reset (rst_n low, synchronous): both stages empty, state set to stopped
//   after opening.
//   Stall: while out_tready is low a waiting result holds; the input register
//   still takes one more beat, then in_tready drops until the result drains.
module gate_motor_controller_fsm
  import gmc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [0] stop_switch [1] stop_button [2] open_limit [3] close_limit
  // [4] reverse_delay_done [5] open_request [6] aux_open_request
  // [7] single_button [8] close_request [9] reverse_request
  // [10] reverse_pause_done [15:11] zero
  input  logic [15:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [1:0] motor_drive [2] clear_reverse_delay [3] clear_reverse_pause
  // [6:4] gate_state [7] zero
  output logic [7:0]  out_tdata
);

  // Input stage
  logic     in_valid_r;
  gmc_in_t  in_beat_r;
  gmc_in_t  in_beat_nxt;

  // Result stage
  logic       out_valid_r;
  logic       out_valid_nxt;
  drive_t     drive_r;
  logic       clr_dly_r;
  logic       clr_pause_r;

  // Controller state
  gate_st_t   state_r;
  gate_st_t   state_nxt;
  drive_t     drive_nxt;
  logic       clr_dly_nxt;
  logic       clr_pause_nxt;

  logic       advance;
  logic       open_cmd;

  // A beat moves on when the result slot is free or being drained
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_comb begin
    in_beat_nxt.stop               = in_tdata[0] | in_tdata[1];
    in_beat_nxt.open_limit         = in_tdata[2];
    in_beat_nxt.close_limit        = in_tdata[3];
    in_beat_nxt.reverse_delay_done = in_tdata[4];
    in_beat_nxt.open_request       = in_tdata[5];
    in_beat_nxt.aux_open_request   = in_tdata[6];
    in_beat_nxt.single_button      = in_tdata[7];
    in_beat_nxt.close_request      = in_tdata[8];
    in_beat_nxt.reverse_request    = in_tdata[9];
    in_beat_nxt.reverse_pause_done = in_tdata[10];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_beat_r <= in_beat_nxt;
    end
  end

  assign open_cmd = in_beat_r.open_request | in_beat_r.aux_open_request;

  // Next state by fixed priority; outputs follow the current state
  always_comb begin
    state_nxt     = state_r;
    drive_nxt     = DRIVE_STOP;
    clr_dly_nxt   = 1'b0;
    clr_pause_nxt = 1'b0;
    case (state_r)
      ST_STOP_OPEN, ST_STOP_CLOSE: begin
        if (in_beat_r.stop) begin
          state_nxt = state_r;
        end else if (in_beat_r.open_limit) begin
          state_nxt = ST_OPEN_LIMIT;
        end else if (in_beat_r.close_limit) begin
          state_nxt = ST_CLOSE_LIMIT;
        end else if (in_beat_r.reverse_delay_done) begin
          if (open_cmd) begin
            state_nxt = ST_OPEN;
          end else if (in_beat_r.single_button) begin
            // step command toggles direction from the last stop
            state_nxt = (state_r == ST_STOP_OPEN) ? ST_CLOSE : ST_OPEN;
          end else if (in_beat_r.close_request) begin
            state_nxt = ST_CLOSE;
          end
        end
      end
      ST_OPEN: begin
        drive_nxt   = DRIVE_OPEN;
        clr_dly_nxt = 1'b1;
        if (in_beat_r.stop) begin
          state_nxt = ST_STOP_CLOSE;
        end else if (in_beat_r.open_limit) begin
          state_nxt = ST_OPEN_LIMIT;
        end else if (in_beat_r.single_button) begin
          state_nxt = ST_STOP_OPEN;
        end
      end
      ST_CLOSE: begin
        drive_nxt     = DRIVE_CLOSE;
        clr_dly_nxt   = 1'b1;
        clr_pause_nxt = 1'b1;
        if (in_beat_r.stop) begin
          state_nxt = ST_STOP_OPEN;
        end else if (in_beat_r.close_limit) begin
          state_nxt = ST_CLOSE_LIMIT;
        end else if (open_cmd) begin
          state_nxt = ST_REVERSE;
        end else if (in_beat_r.single_button) begin
          state_nxt = ST_STOP_CLOSE;
        end else if (in_beat_r.reverse_request) begin
          state_nxt = ST_REVERSE;
        end
      end
      ST_REVERSE: begin
        if (in_beat_r.reverse_pause_done) begin
          state_nxt = ST_OPEN;
        end
      end
      ST_OPEN_LIMIT: begin
        if (!(in_beat_r.stop || open_cmd || in_beat_r.reverse_request) &&
            in_beat_r.reverse_delay_done &&
            (in_beat_r.close_request || in_beat_r.single_button)) begin
          state_nxt = ST_CLOSE;
        end
      end
      ST_CLOSE_LIMIT: begin
        if (!in_beat_r.stop && in_beat_r.reverse_delay_done &&
            (open_cmd || in_beat_r.single_button)) begin
          state_nxt = ST_OPEN;
        end
      end
      default: begin
        state_nxt = ST_STOP_OPEN;
      end
    endcase
  end

  assign out_valid_nxt = advance || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_STOP_OPEN;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      drive_r     <= drive_nxt;
      clr_dly_r   <= clr_dly_nxt;
      clr_pause_r <= clr_pause_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, state_code(state_r), clr_pause_r, clr_dly_r, drive_r};

`include "gate_motor_controller_fsm_assert.svh"

  // result beat reports the state the controller moved to
  `GMC_ASSERT_NEXT(a_state_reported, advance, out_tdata[6:4] == state_code(state_r), "gate_state mismatch")
  // close drive always comes with both timer clears
  `GMC_ASSERT_NOW(a_close_clears, out_valid_r && drive_r == DRIVE_CLOSE, clr_dly_r && clr_pause_r, "close without clears")
  // state only moves with a beat
  `GMC_ASSERT_NEXT(a_state_hold, !advance, $stable(state_r), "state moved without a beat")
  // a held input beat is never dropped
  `GMC_ASSERT_NEXT(a_in_kept, in_valid_r && !advance, in_valid_r, "input beat lost")

endmodule

// File: sim/tb_gate_motor_controller_fsm.sv
// Testbench for gate_motor_controller_fsm: stream driver, result monitor, in-bench state predictor.
module tb_gate_motor_controller_fsm
  import gmc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // Input beat bit masks, lowest bit first, matching the in_tdata layout
  localparam logic [10:0] M_STOP_SW    = 11'h001;
  localparam logic [10:0] M_STOP_BTN   = 11'h002;
  localparam logic [10:0] M_OPEN_LIM   = 11'h004;
  localparam logic [10:0] M_CLOSE_LIM  = 11'h008;
  localparam logic [10:0] M_REV_DELAY  = 11'h010;
  localparam logic [10:0] M_OPEN_REQ   = 11'h020;
  localparam logic [10:0] M_AUX_OPEN   = 11'h040;
  localparam logic [10:0] M_SINGLE     = 11'h080;
  localparam logic [10:0] M_CLOSE_REQ  = 11'h100;
  localparam logic [10:0] M_REV_REQ    = 11'h200;
  localparam logic [10:0] M_REV_PAUSE  = 11'h400;
  localparam logic [10:0] M_ALL        = 11'h7FF;

  localparam int STALL_LIMIT = 1000;  // cycles with no beat on either side
  localparam int LONG_HOLD   = 60;    // receiver back-pressure stretch

  typedef struct {
    drive_t     drive;
    logic       clr_delay;
    logic       clr_pause;
    logic [2:0] state;
  } gate_tick_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;

  logic [10:0]       tick_backlog[$];       // ticks waiting to be offered
  gate_tick_result_t predicted_outputs[$];  // results owed by the DUT
  logic [2:0]        gate_state_q = GS_STOP_OPEN;

  bit idling_on = 1'b1;
  int send_gap = 0;
  int hold_cnt = 0;
  int results_seen = 0;
  int next_long_hold = 100;
  int error_count = 0;
  int quiet_cycles = 0;

  gate_motor_controller_fsm dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #4 clk = ~clk;

  // Next-state and output prediction for one accepted tick.
  // Drive and clears follow the state held before the tick; state reports after.
  task automatic advance_gate_state(input logic [10:0] t);
    logic stop, olim, clim, dly, opn, single, cls, rev, pause;
    logic [2:0] nxt;
    gate_tick_result_t r;
    stop   = |(t & (M_STOP_SW | M_STOP_BTN));
    olim   = |(t & M_OPEN_LIM);
    clim   = |(t & M_CLOSE_LIM);
    dly    = |(t & M_REV_DELAY);
    opn    = |(t & (M_OPEN_REQ | M_AUX_OPEN));  // open and aux open act alike
    single = |(t & M_SINGLE);
    cls    = |(t & M_CLOSE_REQ);
    rev    = |(t & M_REV_REQ);
    pause  = |(t & M_REV_PAUSE);
    nxt = gate_state_q;
    r.drive = DRIVE_STOP;
    r.clr_delay = 1'b0;
    r.clr_pause = 1'b0;
    case (gate_state_q)
      GS_STOP_OPEN, GS_STOP_CLOSE: begin
        if (stop) begin
          nxt = gate_state_q;
        end else if (olim) begin
          nxt = GS_OPEN_LIMIT;
        end else if (clim) begin
          nxt = GS_CLOSE_LIMIT;
        end else if (dly) begin
          if (opn) begin
            nxt = GS_OPEN;
          end else if (single) begin
            // single button closes from stopOpen and opens from stopClose
            nxt = (gate_state_q == GS_STOP_OPEN) ? GS_CLOSE : GS_OPEN;
          end else if (cls) begin
            nxt = GS_CLOSE;
          end
        end
      end
      GS_OPEN: begin
        r.drive = DRIVE_OPEN;
        r.clr_delay = 1'b1;
        if (stop) begin
          nxt = GS_STOP_CLOSE;
        end else if (olim) begin
          nxt = GS_OPEN_LIMIT;
        end else if (single) begin
          nxt = GS_STOP_OPEN;
        end
      end
      GS_CLOSE: begin
        r.drive = DRIVE_CLOSE;
        r.clr_delay = 1'b1;
        r.clr_pause = 1'b1;
        if (stop) begin
          nxt = GS_STOP_OPEN;
        end else if (clim) begin
          nxt = GS_CLOSE_LIMIT;
        end else if (opn) begin
          nxt = GS_REVERSE;
        end else if (single) begin
          nxt = GS_STOP_CLOSE;
        end else if (rev) begin
          nxt = GS_REVERSE;
        end
      end
      GS_REVERSE: begin
        if (pause) nxt = GS_OPEN;
      end
      GS_OPEN_LIMIT: begin
        if (!(stop || opn || rev) && dly && (cls || single)) nxt = GS_CLOSE;
      end
      GS_CLOSE_LIMIT: begin
        if (!stop && dly && (opn || single)) nxt = GS_OPEN;
      end
      default: begin
        nxt = GS_STOP_OPEN;
      end
    endcase
    gate_state_q = nxt;
    r.state = nxt;
    predicted_outputs.push_back(r);
  endtask

  task automatic report_mismatch(input string field, input int expv, input int gotv);
    $display("mismatch at result %0d: %s expected %0d got %0d",
             results_seen, field, expv, gotv);
    error_count++;
  endtask

  // Mostly plausible operating ticks: stops rare so the gate actually moves;
  // a share of fully random ticks as noise.
  function automatic logic [10:0] random_tick();
    logic [10:0] t;
    if ($urandom_range(0, 9) < 2) begin
      t = 11'($urandom) & M_ALL;
    end else begin
      t = '0;
      if ($urandom_range(0, 15) == 0) t |= M_STOP_SW;
      if ($urandom_range(0, 15) == 0) t |= M_STOP_BTN;
      if ($urandom_range(0, 7) == 0)  t |= M_OPEN_LIM;
      if ($urandom_range(0, 7) == 0)  t |= M_CLOSE_LIM;
      if ($urandom_range(0, 1) == 0)  t |= M_REV_DELAY;
      if ($urandom_range(0, 5) == 0)  t |= M_OPEN_REQ;
      if ($urandom_range(0, 5) == 0)  t |= M_AUX_OPEN;
      if ($urandom_range(0, 4) == 0)  t |= M_SINGLE;
      if ($urandom_range(0, 3) == 0)  t |= M_CLOSE_REQ;
      if ($urandom_range(0, 5) == 0)  t |= M_REV_REQ;
      if ($urandom_range(0, 2) == 0)  t |= M_REV_PAUSE;
    end
    return t;
  endfunction

  // Driver: predicts on each accepted beat, then offers the next tick or idles.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gate_state_q = GS_STOP_OPEN;
    end else begin
      if (in_tvalid && in_tready) advance_gate_state(in_tdata[10:0]);
      if (!in_tvalid || in_tready) begin
        if (idling_on && send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (tick_backlog.size() == 0) begin
          in_tvalid <= 1'b0;
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(1, 13) - 1;
          in_tvalid <= 1'b0;
        end else begin
          in_tvalid <= 1'b1;
          in_tdata <= {5'd0, tick_backlog.pop_front()};
        end
      end
    end
  end

  // Monitor: checks each result beat against the oldest prediction, and
  // drives out_tready with random stalls plus occasional long holds.
  always @(posedge clk) begin
    gate_tick_result_t e;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (predicted_outputs.size() == 0) begin
          report_mismatch("pending results", 1, 0);
        end else begin
          e = predicted_outputs.pop_front();
          if (out_tdata[1:0] !== e.drive)
            report_mismatch("motor_drive", e.drive, out_tdata[1:0]);
          if (out_tdata[2] !== e.clr_delay)
            report_mismatch("clear_reverse_delay", e.clr_delay, out_tdata[2]);
          if (out_tdata[3] !== e.clr_pause)
            report_mismatch("clear_reverse_pause", e.clr_pause, out_tdata[3]);
          if (out_tdata[6:4] !== e.state)
            report_mismatch("gate_state", e.state, out_tdata[6:4]);
        end
        results_seen++;
      end
      if (idling_on && hold_cnt > 0) begin
        hold_cnt--;
        out_tready <= 1'b0;
      end else if (idling_on && results_seen >= next_long_hold) begin
        // long back-pressure: sender keeps offering, DUT must fill and stall
        hold_cnt = LONG_HOLD - 1;
        next_long_hold += 800;
        out_tready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        hold_cnt = $urandom_range(1, 13) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  task automatic wait_drained();
    while (tick_backlog.size() != 0 || in_tvalid || predicted_outputs.size() != 0)
      @(negedge clk);
  endtask

  task automatic queue_random(input int n);
    repeat (n) tick_backlog.push_back(random_tick());
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // Directed walk through every state and transition class, from stopOpen
    tick_backlog.push_back('0);                              // idle, stays
    tick_backlog.push_back(M_ALL);                           // everything high, stop wins
    tick_backlog.push_back(M_STOP_BTN);                      // button stop alone
    tick_backlog.push_back(M_REV_DELAY | M_SINGLE);          // step after open: close
    tick_backlog.push_back(M_REV_REQ);                       // obstruction: reverse
    tick_backlog.push_back('0);                              // reverse pause holds
    tick_backlog.push_back(M_REV_PAUSE);                     // pause done: open
    tick_backlog.push_back(M_SINGLE);                        // step while opening: stop
    tick_backlog.push_back(M_REV_DELAY | M_OPEN_REQ);        // open again
    tick_backlog.push_back(M_STOP_SW);                       // stop while opening
    tick_backlog.push_back(M_REV_DELAY | M_SINGLE);          // step after close: open
    tick_backlog.push_back(M_OPEN_LIM);                      // open limit reached
    tick_backlog.push_back(M_REV_DELAY | M_CLOSE_REQ | M_AUX_OPEN); // aux holds it open
    tick_backlog.push_back(M_REV_DELAY | M_SINGLE);          // step from open limit: close
    tick_backlog.push_back(M_AUX_OPEN);                      // aux open while closing
    tick_backlog.push_back(M_REV_PAUSE | M_STOP_SW);         // pause ignores stop
    tick_backlog.push_back(M_STOP_BTN);                      // stop while opening
    tick_backlog.push_back(M_REV_DELAY | M_CLOSE_REQ);       // close from stopped
    tick_backlog.push_back(M_SINGLE);                        // step while closing: stop
    tick_backlog.push_back(M_CLOSE_LIM);                     // close limit from stopped
    tick_backlog.push_back(M_REV_DELAY | M_SINGLE | M_STOP_BTN); // stop blocks leaving
    tick_backlog.push_back(M_REV_DELAY | M_AUX_OPEN);        // leave close limit: open
    tick_backlog.push_back(M_OPEN_LIM | M_STOP_SW);          // stop beats limit
    tick_backlog.push_back(M_OPEN_LIM);                      // open limit from stopped
    tick_backlog.push_back(M_REV_DELAY | M_CLOSE_REQ);       // close from open limit
    tick_backlog.push_back(M_CLOSE_LIM | M_OPEN_REQ);        // limit beats open request
    tick_backlog.push_back(M_REV_DELAY | M_OPEN_REQ);        // leave close limit: open
    tick_backlog.push_back(M_STOP_SW | M_STOP_BTN);          // stop while opening
    wait_drained();

    // Random traffic, idling on then off, then on again
    queue_random(400);
    while (tick_backlog.size() > 100) @(negedge clk);
    idling_on = 1'b0;
    queue_random(300);
    while (tick_backlog.size() > 100) @(negedge clk);
    idling_on = 1'b1;
    queue_random(450);
    wait_drained();  // sender holds until every result is back

    // Final stretch at full rate
    idling_on = 1'b0;
    queue_random(300);
    wait_drained();

    repeat (8) @(negedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
